// File: rtl/cau_pkg.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Request type codes and the width of the request type field.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int REQ_TYPE_W = 4;

    localparam logic [REQ_TYPE_W-1:0] OP_ADD  = 4'd0;
    localparam logic [REQ_TYPE_W-1:0] OP_SUB  = 4'd1;
    localparam logic [REQ_TYPE_W-1:0] OP_MUL  = 4'd2;
    localparam logic [REQ_TYPE_W-1:0] OP_DIV  = 4'd3;
    localparam logic [REQ_TYPE_W-1:0] OP_GT   = 4'd4;
    localparam logic [REQ_TYPE_W-1:0] OP_GE   = 4'd5;
    localparam logic [REQ_TYPE_W-1:0] OP_LT   = 4'd6;
    localparam logic [REQ_TYPE_W-1:0] OP_LE   = 4'd7;
    localparam logic [REQ_TYPE_W-1:0] OP_EQ   = 4'd8;
    localparam logic [REQ_TYPE_W-1:0] OP_NE   = 4'd9;
    localparam logic [REQ_TYPE_W-1:0] OP_CONJ = 4'd10;
    localparam logic [REQ_TYPE_W-1:0] OP_MOD  = 4'd11;

    // Unused codes; every result field is zero for these.
    localparam logic [REQ_TYPE_W-1:0] OP_RSVD_FIRST = 4'd12;
    localparam logic [REQ_TYPE_W-1:0] OP_RSVD_LAST  = 4'd15;

endpackage

// File: rtl/cau_req_if.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit request channel
// Valid/ready channel carrying one opcode and two complex operands.
// ----------------------------------------------------------------------------
interface cau_req_if #(
    parameter int WORD_BITS = 32
);
    logic                               valid;
    logic                               ready;
    logic [cau_pkg::REQ_TYPE_W-1:0]     req_type;
    logic signed [WORD_BITS-1:0]        a_real;
    logic signed [WORD_BITS-1:0]        a_imag;
    logic signed [WORD_BITS-1:0]        b_real;
    logic signed [WORD_BITS-1:0]        b_imag;

    modport source (
        output valid, req_type, a_real, a_imag, b_real, b_imag,
        input  ready
    );
    modport sink (
        input  valid, req_type, a_real, a_imag, b_real, b_imag,
        output ready
    );
endinterface

// File: rtl/cau_res_if.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit result channel
// Valid/ready channel carrying one complex result and its status flags.
// ----------------------------------------------------------------------------
interface cau_res_if #(
    parameter int WORD_BITS = 32
);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] res_real;
    logic signed [WORD_BITS-1:0] res_imag;
    logic                        compare_true;
    logic                        divide_by_zero;
    logic                        saturated;

    modport source (
        output valid, res_real, res_imag, compare_true, divide_by_zero, saturated,
        input  ready
    );
    modport sink (
        input  valid, res_real, res_imag, compare_true, divide_by_zero, saturated,
        output ready
    );
endinterface

// File: rtl/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Pipelined ALU for complex operands in signed fixed point.
// ----------------------------------------------------------------------------
// The unit takes one request per cycle, each an opcode and two complex
// operands A and B in signed fixed point (WORD_BITS wide, FRAC_BITS fraction
// bits), and returns exactly one result per request, in request order. It
// computes the sum, difference, product (rounded to nearest, ties upward),
// quotient A*conj(B)/|B|^2 (rounded to nearest, ties away from zero), the
// conjugate of A, the modulus of A (floor of the square root), compares of
// the squared moduli, and exact equality compares. Results that leave the
// word range are clipped and flagged with saturated; a zero divisor gives a
// zero quotient with divide_by_zero set. Unused opcodes return all zeros.
// Throughput is one request per cycle while the request side is not stalled.
// From acceptance to the output, a request passes three front stages
// (multipliers, adders, compare and divide setup), then WORD_BITS iteration
// stages that each produce one quotient bit of both divisions and one bit of
// the square root, then the output register. A two-entry output buffer lets
// the pipeline keep moving while one result waits; the request side stalls
// only when both entries are occupied.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cau_req_if.sink  i_req,
    cau_res_if.source o_res
);
    localparam int W  = WORD_BITS;
    localparam int PW = 2*W;
    localparam int DW = 2*W + 1;
    localparam int NW = 2*W + FRAC_BITS + 2;
    localparam int HW = NW - W;
    localparam int CW = (HW > DW) ? HW : DW;
    localparam int SW = W + 2;
    localparam int OW = cau_pkg::REQ_TYPE_W;

    typedef struct packed {
        logic [OW-1:0] op;
        logic [W-1:0]  pre_re;
        logic [W-1:0]  pre_im;
        logic          pre_cmp;
        logic          pre_sat;
        logic          dz;
        logic          neg_r;
        logic          neg_i;
        logic          ovf_r;
        logic          ovf_i;
    } t_side;

    typedef struct packed {
        logic [W-1:0] res_real;
        logic [W-1:0] res_imag;
        logic         compare_true;
        logic         divide_by_zero;
        logic         saturated;
    } t_res;

    localparam int SIDE_W = $bits(t_side);

    localparam logic [W-1:0] MAX_W = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_W = {1'b1, {(W-1){1'b0}}};

    // Clip a one-bit-grown sum to the word; top bit of the result is the flag.
    function automatic logic [W:0] clip_w1(input logic [W:0] v);
        logic [W:0] res;
        if (v[W] != v[W-1]) begin
            res = {1'b1, v[W], {(W-1){~v[W]}}};
        end else begin
            res = {1'b0, v[W-1:0]};
        end
        return res;
    endfunction

    // Apply sign and range limits to a quotient magnitude.
    function automatic logic [W:0] clip_q(input logic [W-1:0] q, input logic neg,
                                         input logic ovf);
        logic [W:0] res;
        if (ovf) begin
            res = {1'b1, neg ? MIN_W : MAX_W};
        end else if (!neg) begin
            res = q[W-1] ? {1'b1, MAX_W} : {1'b0, q};
        end else if (q[W-1] && (|q[W-2:0])) begin
            res = {1'b1, MIN_W};
        end else begin
            res = {1'b0, W'(-q)};
        end
        return res;
    endfunction

    // Global advance: the pipeline moves whenever the output skid entry is free.
    logic en;
    logic r_ov, r_sv;
    t_res r_od, r_sd;

    assign en          = !r_sv;
    assign i_req.ready = en;

    // ---------------- Stage 1: products and the simple operations ----------
    logic              r1_v;
    logic [OW-1:0]     r1_op;
    logic              r1_eq;
    logic signed [PW-1:0] r1_prr, r1_pii, r1_pri, r1_pir;
    logic signed [PW-1:0] r1_paa, r1_pai, r1_pbb, r1_pbi;
    logic [W-1:0]      r1_pre_re, r1_pre_im;
    logic              r1_pre_sat;

    logic [W:0] n1_re_raw, n1_im_raw, n1_re_cl, n1_im_cl;

    always_comb begin
        n1_re_raw = '0;
        n1_im_raw = '0;
        case (i_req.req_type)
            cau_pkg::OP_ADD: begin
                n1_re_raw = (W+1)'(i_req.a_real) + (W+1)'(i_req.b_real);
                n1_im_raw = (W+1)'(i_req.a_imag) + (W+1)'(i_req.b_imag);
            end
            cau_pkg::OP_SUB: begin
                n1_re_raw = (W+1)'(i_req.a_real) - (W+1)'(i_req.b_real);
                n1_im_raw = (W+1)'(i_req.a_imag) - (W+1)'(i_req.b_imag);
            end
            cau_pkg::OP_CONJ: begin
                n1_re_raw = (W+1)'(i_req.a_real);
                n1_im_raw = (W+1)'(-((W+1)'(i_req.a_imag)));
            end
            default: begin
                n1_re_raw = '0;
                n1_im_raw = '0;
            end
        endcase
        n1_re_cl = clip_w1(n1_re_raw);
        n1_im_cl = clip_w1(n1_im_raw);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_op      <= i_req.req_type;
            r1_eq      <= (i_req.a_real == i_req.b_real) && (i_req.a_imag == i_req.b_imag);
            r1_prr     <= PW'(i_req.a_real) * PW'(i_req.b_real);
            r1_pii     <= PW'(i_req.a_imag) * PW'(i_req.b_imag);
            r1_pri     <= PW'(i_req.a_real) * PW'(i_req.b_imag);
            r1_pir     <= PW'(i_req.a_imag) * PW'(i_req.b_real);
            r1_paa     <= PW'(i_req.a_real) * PW'(i_req.a_real);
            r1_pai     <= PW'(i_req.a_imag) * PW'(i_req.a_imag);
            r1_pbb     <= PW'(i_req.b_real) * PW'(i_req.b_real);
            r1_pbi     <= PW'(i_req.b_imag) * PW'(i_req.b_imag);
            r1_pre_re  <= n1_re_cl[W-1:0];
            r1_pre_im  <= n1_im_cl[W-1:0];
            r1_pre_sat <= n1_re_cl[W] | n1_im_cl[W];
        end
    end

    // ---------------- Stage 2: squared moduli and cross sums ---------------
    localparam logic signed [PW:0] HALF = (PW+1)'(1) <<< (FRAC_BITS - 1);

    logic                 r2_v;
    logic [OW-1:0]        r2_op;
    logic                 r2_eq;
    logic [W-1:0]         r2_pre_re, r2_pre_im;
    logic                 r2_pre_sat;
    logic [PW-1:0]        r2_ma, r2_mb;
    logic signed [PW:0]   r2_mre, r2_mim, r2_nr, r2_ni;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_op      <= r1_op;
            r2_eq      <= r1_eq;
            r2_pre_re  <= r1_pre_re;
            r2_pre_im  <= r1_pre_im;
            r2_pre_sat <= r1_pre_sat;
            r2_ma      <= $unsigned(r1_paa) + $unsigned(r1_pai);
            r2_mb      <= $unsigned(r1_pbb) + $unsigned(r1_pbi);
            r2_mre     <= (PW+1)'(r1_prr) - (PW+1)'(r1_pii) + HALF;
            r2_mim     <= (PW+1)'(r1_pri) + (PW+1)'(r1_pir) + HALF;
            r2_nr      <= (PW+1)'(r1_prr) + (PW+1)'(r1_pii);
            r2_ni      <= (PW+1)'(r1_pir) - (PW+1)'(r1_pri);
        end
    end

    // ---------------- Stage 3: compares, product clip, divide setup --------
    localparam logic signed [PW:0] LIM_HI = {{(PW-W+2){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [PW:0] LIM_LO = {{(PW-W+2){1'b1}}, {(W-1){1'b0}}};

    logic signed [PW:0] n3_mre_sh, n3_mim_sh;
    logic [W-1:0]       n3_mul_re, n3_mul_im;
    logic               n3_mul_sat;
    logic               n3_cmp;
    logic               n3_neg_r, n3_neg_i;
    logic [PW:0]        n3_abs_r, n3_abs_i;
    logic [NW-1:0]      n3_num_r, n3_num_i;
    logic [DW-1:0]      n3_d;
    logic               n3_ovf_r, n3_ovf_i;
    t_side              n3_side;

    always_comb begin
        n3_mre_sh  = r2_mre >>> FRAC_BITS;
        n3_mim_sh  = r2_mim >>> FRAC_BITS;
        n3_mul_sat = 1'b0;
        if (n3_mre_sh > LIM_HI) begin
            n3_mul_re  = MAX_W;
            n3_mul_sat = 1'b1;
        end else if (n3_mre_sh < LIM_LO) begin
            n3_mul_re  = MIN_W;
            n3_mul_sat = 1'b1;
        end else begin
            n3_mul_re = n3_mre_sh[W-1:0];
        end
        if (n3_mim_sh > LIM_HI) begin
            n3_mul_im  = MAX_W;
            n3_mul_sat = 1'b1;
        end else if (n3_mim_sh < LIM_LO) begin
            n3_mul_im  = MIN_W;
            n3_mul_sat = 1'b1;
        end else begin
            n3_mul_im = n3_mim_sh[W-1:0];
        end

        // Dividend scaled by 2^(FRAC_BITS+1) plus |B|^2 (half the divisor) gives round-to-nearest.
        n3_neg_r = r2_nr[PW];
        n3_neg_i = r2_ni[PW];
        n3_abs_r = n3_neg_r ? (PW+1)'(-r2_nr) : r2_nr;
        n3_abs_i = n3_neg_i ? (PW+1)'(-r2_ni) : r2_ni;
        n3_num_r = {NW'(n3_abs_r[PW-1:0]) << (FRAC_BITS + 1)} + NW'(r2_mb);
        n3_num_i = {NW'(n3_abs_i[PW-1:0]) << (FRAC_BITS + 1)} + NW'(r2_mb);
        n3_d     = {r2_mb, 1'b0};
        n3_ovf_r = CW'(n3_num_r[NW-1:W]) >= CW'(n3_d);
        n3_ovf_i = CW'(n3_num_i[NW-1:W]) >= CW'(n3_d);

        case (r2_op)
            cau_pkg::OP_GT: n3_cmp = r2_ma >  r2_mb;
            cau_pkg::OP_GE: n3_cmp = r2_ma >= r2_mb;
            cau_pkg::OP_LT: n3_cmp = r2_ma <  r2_mb;
            cau_pkg::OP_LE: n3_cmp = r2_ma <= r2_mb;
            cau_pkg::OP_EQ: n3_cmp = r2_eq;
            cau_pkg::OP_NE: n3_cmp = !r2_eq;
            default:        n3_cmp = 1'b0;
        endcase

        n3_side.op      = r2_op;
        n3_side.pre_cmp = n3_cmp;
        n3_side.dz      = (r2_op == cau_pkg::OP_DIV) && (r2_mb == '0);
        n3_side.neg_r   = n3_neg_r;
        n3_side.neg_i   = n3_neg_i;
        n3_side.ovf_r   = n3_ovf_r;
        n3_side.ovf_i   = n3_ovf_i;
        case (r2_op)
            cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_CONJ: begin
                n3_side.pre_re  = r2_pre_re;
                n3_side.pre_im  = r2_pre_im;
                n3_side.pre_sat = r2_pre_sat;
            end
            cau_pkg::OP_MUL: begin
                n3_side.pre_re  = n3_mul_re;
                n3_side.pre_im  = n3_mul_im;
                n3_side.pre_sat = n3_mul_sat;
            end
            default: begin
                n3_side.pre_re  = '0;
                n3_side.pre_im  = '0;
                n3_side.pre_sat = 1'b0;
            end
        endcase
    end

    // Iteration chain; index 0 is the stage 3 register, index W the last step.
    logic              s_v     [0:W];
    logic [DW-1:0]     s_d     [0:W];
    logic [DW-1:0]     s_rem_r [0:W];
    logic [W-1:0]      s_low_r [0:W];
    logic [DW-1:0]     s_rem_i [0:W];
    logic [W-1:0]      s_low_i [0:W];
    logic [SW-1:0]     s_srem  [0:W];
    logic [W-1:0]      s_sy    [0:W];
    logic [PW-1:0]     s_sm    [0:W];
    logic [SIDE_W-1:0] s_side  [0:W];

    logic              r3_v;
    logic [DW-1:0]     r3_d, r3_rem_r, r3_rem_i;
    logic [W-1:0]      r3_low_r, r3_low_i;
    logic [PW-1:0]     r3_sm;
    t_side             r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    // On overflow the starting remainder is zeroed; the flag overrides the quotient.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_d     <= n3_d;
            r3_rem_r <= n3_ovf_r ? '0 : DW'(CW'(n3_num_r[NW-1:W]));
            r3_rem_i <= n3_ovf_i ? '0 : DW'(CW'(n3_num_i[NW-1:W]));
            r3_low_r <= n3_num_r[W-1:0];
            r3_low_i <= n3_num_i[W-1:0];
            r3_sm    <= r2_ma;
            r3_side  <= n3_side;
        end
    end

    assign s_v[0]     = r3_v;
    assign s_d[0]     = r3_d;
    assign s_rem_r[0] = r3_rem_r;
    assign s_low_r[0] = r3_low_r;
    assign s_rem_i[0] = r3_rem_i;
    assign s_low_i[0] = r3_low_i;
    assign s_srem[0]  = '0;
    assign s_sy[0]    = '0;
    assign s_sm[0]    = r3_sm;
    assign s_side[0]  = r3_side;

    for (genvar k = 0; k < W; k++) begin : g_step
        cau_step #(
            .W      (W),
            .SIDE_W (SIDE_W)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (s_v[k]),
            .i_d     (s_d[k]),
            .i_rem_r (s_rem_r[k]),
            .i_low_r (s_low_r[k]),
            .i_rem_i (s_rem_i[k]),
            .i_low_i (s_low_i[k]),
            .i_srem  (s_srem[k]),
            .i_sy    (s_sy[k]),
            .i_sm    (s_sm[k]),
            .i_side  (s_side[k]),
            .o_valid (s_v[k+1]),
            .o_d     (s_d[k+1]),
            .o_rem_r (s_rem_r[k+1]),
            .o_low_r (s_low_r[k+1]),
            .o_rem_i (s_rem_i[k+1]),
            .o_low_i (s_low_i[k+1]),
            .o_srem  (s_srem[k+1]),
            .o_sy    (s_sy[k+1]),
            .o_sm    (s_sm[k+1]),
            .o_side  (s_side[k+1])
        );
    end

    // ---------------- Result selection ---------------------------------------
    t_side      fin_side;
    t_res       fin_d;
    logic       fin_v;
    logic [W:0] fin_qr, fin_qi;

    always_comb begin
        fin_side = t_side'(s_side[W]);
        fin_qr   = clip_q(s_low_r[W], fin_side.neg_r, fin_side.ovf_r);
        fin_qi   = clip_q(s_low_i[W], fin_side.neg_i, fin_side.ovf_i);
        fin_d.compare_true   = fin_side.pre_cmp;
        fin_d.divide_by_zero = 1'b0;
        case (fin_side.op)
            cau_pkg::OP_DIV: begin
                if (fin_side.dz) begin
                    fin_d.res_real       = '0;
                    fin_d.res_imag       = '0;
                    fin_d.saturated      = 1'b0;
                    fin_d.divide_by_zero = 1'b1;
                end else begin
                    fin_d.res_real  = fin_qr[W-1:0];
                    fin_d.res_imag  = fin_qi[W-1:0];
                    fin_d.saturated = fin_qr[W] | fin_qi[W];
                end
            end
            cau_pkg::OP_MOD: begin
                fin_d.res_real  = s_sy[W][W-1] ? MAX_W : s_sy[W];
                fin_d.res_imag  = '0;
                fin_d.saturated = s_sy[W][W-1];
            end
            default: begin
                fin_d.res_real  = fin_side.pre_re;
                fin_d.res_imag  = fin_side.pre_im;
                fin_d.saturated = fin_side.pre_sat;
            end
        endcase
    end

    assign fin_v = s_v[W] && en;

    // ---------------- Output register and skid entry ---------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (o_res.ready || !r_ov) begin
            r_ov <= r_sv || fin_v;
            r_sv <= 1'b0;
        end else if (fin_v) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res.ready || !r_ov) begin
            r_od <= r_sv ? r_sd : fin_d;
        end else if (fin_v) begin
            r_sd <= fin_d;
        end
    end

    assign o_res.valid          = r_ov;
    assign o_res.res_real       = r_od.res_real;
    assign o_res.res_imag       = r_od.res_imag;
    assign o_res.compare_true   = r_od.compare_true;
    assign o_res.divide_by_zero = r_od.divide_by_zero;
    assign o_res.saturated      = r_od.saturated;

    // ---------------- Assertions -------------------------------------------------
    // The skid entry is only ever filled behind a waiting output.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid entry holds a result while the output is empty");

    // A buffered result moves up as soon as the output is taken.
    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && o_res.ready && r_sv) |=> (r_ov && !r_sv))
        else $error("buffered result was not moved to the output");

    // A zero divisor always yields a clean zero result.
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.divide_by_zero) |->
        (o_res.res_real == '0 && o_res.res_imag == '0 && !o_res.saturated &&
         !o_res.compare_true))
        else $error("divide by zero result is not zero");

    // A true compare carries no numeric result.
    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.compare_true) |->
        (o_res.res_real == '0 && o_res.res_imag == '0 && !o_res.saturated))
        else $error("compare result carries a nonzero value");

endmodule

// File: rtl/cau_step.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit iteration stage
// One registered step of two restoring divisions sharing a divisor and one
// digit of an integer square root, with pass-through side information.
// ----------------------------------------------------------------------------
module cau_step #(
    parameter int W      = 32,
    parameter int SIDE_W = 75
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [2*W:0]      i_d,
    input  logic [2*W:0]      i_rem_r,
    input  logic [W-1:0]      i_low_r,
    input  logic [2*W:0]      i_rem_i,
    input  logic [W-1:0]      i_low_i,
    input  logic [W+1:0]      i_srem,
    input  logic [W-1:0]      i_sy,
    input  logic [2*W-1:0]    i_sm,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [2*W:0]      o_d,
    output logic [2*W:0]      o_rem_r,
    output logic [W-1:0]      o_low_r,
    output logic [2*W:0]      o_rem_i,
    output logic [W-1:0]      o_low_i,
    output logic [W+1:0]      o_srem,
    output logic [W-1:0]      o_sy,
    output logic [2*W-1:0]    o_sm,
    output logic [SIDE_W-1:0] o_side
);
    localparam int DW = 2*W + 1;
    localparam int SW = W + 2;

    logic [DW:0]   sh_r, sh_i;
    logic          ge_r, ge_i, ge_s;
    logic [SW+1:0] sh_s, trial_s;

    logic [DW-1:0] n_rem_r, n_rem_i;
    logic [W-1:0]  n_low_r, n_low_i, n_sy;
    logic [SW-1:0] n_srem;

    logic              r_valid;
    logic [DW-1:0]     r_d, r_rem_r, r_rem_i;
    logic [W-1:0]      r_low_r, r_low_i, r_sy;
    logic [SW-1:0]     r_srem;
    logic [2*W-1:0]    r_sm;
    logic [SIDE_W-1:0] r_side;

    // Shift one dividend bit into each remainder and subtract the divisor if it fits.
    always_comb begin
        sh_r    = {i_rem_r, i_low_r[W-1]};
        sh_i    = {i_rem_i, i_low_i[W-1]};
        ge_r    = sh_r >= {1'b0, i_d};
        ge_i    = sh_i >= {1'b0, i_d};
        n_rem_r = ge_r ? DW'(sh_r - {1'b0, i_d}) : DW'(sh_r);
        n_rem_i = ge_i ? DW'(sh_i - {1'b0, i_d}) : DW'(sh_i);
        n_low_r = {i_low_r[W-2:0], ge_r};
        n_low_i = {i_low_i[W-2:0], ge_i};
    end

    // Square root digit: bring in two radicand bits and try 4*root + 1.
    always_comb begin
        sh_s    = {i_srem, i_sm[2*W-1:2*W-2]};
        trial_s = {2'b00, i_sy, 2'b01};
        ge_s    = sh_s >= trial_s;
        n_srem  = ge_s ? SW'(sh_s - trial_s) : SW'(sh_s);
        n_sy    = {i_sy[W-2:0], ge_s};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d     <= i_d;
            r_rem_r <= n_rem_r;
            r_low_r <= n_low_r;
            r_rem_i <= n_rem_i;
            r_low_i <= n_low_i;
            r_srem  <= n_srem;
            r_sy    <= n_sy;
            r_sm    <= {i_sm[2*W-3:0], 2'b00};
            r_side  <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;
    assign o_rem_r = r_rem_r;
    assign o_low_r = r_low_r;
    assign o_rem_i = r_rem_i;
    assign o_low_i = r_low_i;
    assign o_srem  = r_srem;
    assign o_sy    = r_sy;
    assign o_sm    = r_sm;
    assign o_side  = r_side;

endmodule
